### sv/go_to_goal_controller_macros.svh
// ----------------------------------------------------------------------------
// go_to_goal_controller assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef GO_TO_GOAL_CONTROLLER_MACROS_SVH
`define GO_TO_GOAL_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
`define GTG_ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error("assertion failed");
`define GTG_ASSERT(lbl, prop) `GTG_ASSERT_CLK(lbl, clk, arst_n, prop)
`else
`define GTG_ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop)
`define GTG_ASSERT(lbl, prop)
`endif

`endif

### sv/gtg_pkg.sv
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared widths, constants and types of the go-to-goal controller.
// ----------------------------------------------------------------------------
`default_nettype none

package gtg_pkg;

	// cordic datapath widths: offsets are q8.16, angles q16 radians
	localparam int X_W    = 28;
	localparam int Z_W    = 20;
	localparam int DIST_W = 19;

	localparam int COORD_W = 16;
	localparam int ANGLE_W = 15;
	localparam int SPEED_W = 15;
	localparam int TURN_W  = 16;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_GOAL_X      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_RADIUS = 2'd3;

	localparam int ANG_HALF_PI = 102944;
	localparam int INV_K_Q16   = 39797;
	localparam int BEARING_MAX = 12868;
	localparam int SPEED_MAX   = 32767;

	localparam int ATAN_N = 24;
	localparam logic [16:0] ATAN_Q16 [ATAN_N] = '{
		17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
		17'd256,   17'd128,   17'd64,    17'd32,   17'd16,   17'd8,    17'd4,    17'd2,
		17'd1,     17'd0,     17'd0,     17'd0,    17'd0,    17'd0,    17'd0,    17'd0
	};

	typedef struct packed {
		logic signed [X_W-1:0] x;
		logic signed [X_W-1:0] y;
		logic signed [Z_W-1:0] z;
	} vec_t;

	typedef enum logic [1:0] {
		PH_FIRST   = 2'd0,
		PH_TRACK   = 2'd1,
		PH_ARRIVED = 2'd2
	} phase_t;

endpackage

`default_nettype wire

### sv/gtg_cordic_cell.sv
// ----------------------------------------------------------------------------
// gtg_cordic_cell
// One vectoring cordic micro-rotation with a fixed shift, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gtg_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  gtg_pkg::vec_t in_vec,
	output logic          out_valid,
	output gtg_pkg::vec_t out_vec
);
	import gtg_pkg::*;

	logic signed [X_W-1:0] xs;
	logic signed [X_W-1:0] ys;
	logic signed [Z_W-1:0] ang;
	logic                  y_pos;
	vec_t                  nxt;
	logic                  valid_q;
	vec_t                  vec_q;

	assign xs    = in_vec.x >>> STEP;
	assign ys    = in_vec.y >>> STEP;
	assign ang   = Z_W'(ATAN_Q16[STEP]);
	assign y_pos = !in_vec.y[X_W-1] && (in_vec.y != '0);

	// rotate toward the x axis
	always_comb begin
		if (y_pos) begin
			nxt.x = in_vec.x + ys;
			nxt.y = in_vec.y - xs;
			nxt.z = in_vec.z + ang;
		end else begin
			nxt.x = in_vec.x - ys;
			nxt.y = in_vec.y + xs;
			nxt.z = in_vec.z - ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		vec_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_vec   = vec_q;

endmodule

`default_nettype wire

### sv/gtg_scale.sv
// ----------------------------------------------------------------------------
// gtg_scale
// Gain correction of the cordic magnitude and rounding and clamping of the bearing.
// ----------------------------------------------------------------------------
`default_nettype none

module gtg_scale (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  gtg_pkg::vec_t                      in_vec,
	input  logic                               zero,
	input  logic                               take,
	output logic                               valid,
	output logic [gtg_pkg::DIST_W-1:0]         distance,
	output logic signed [gtg_pkg::ANGLE_W-1:0] bearing
);
	import gtg_pkg::*;

	localparam int PROD_W = X_W - 1 + 17;
	localparam logic signed [Z_W-1:0] B_MAX = Z_W'(BEARING_MAX);
	localparam logic signed [Z_W-1:0] B_MIN = -Z_W'(BEARING_MAX);

	logic [X_W-2:0]         mag;
	logic [PROD_W-1:0]      prod;
	logic signed [Z_W-1:0]  zr;
	logic signed [Z_W-1:0]  zs;
	logic [DIST_W-1:0]      dist_d;
	logic signed [ANGLE_W-1:0] bear_d;
	logic                   valid_q;
	logic [DIST_W-1:0]      dist_q;
	logic signed [ANGLE_W-1:0] bear_q;

	assign mag  = in_vec.x[X_W-1] ? '0 : in_vec.x[X_W-2:0];
	assign prod = PROD_W'(mag) * PROD_W'(INV_K_Q16) + PROD_W'(1 << 23);
	assign zr   = in_vec.z + Z_W'(8);
	assign zs   = zr >>> 4;

	always_comb begin
		if (zero) begin
			dist_d = '0;
			bear_d = '0;
		end else begin
			dist_d = prod[24 +: DIST_W];
			if (zs > B_MAX) begin
				bear_d = ANGLE_W'(BEARING_MAX);
			end else if (zs < B_MIN) begin
				bear_d = -ANGLE_W'(BEARING_MAX);
			end else begin
				bear_d = zs[ANGLE_W-1:0];
			end
		end
	end

	// hold the result until the output side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_valid) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			dist_q <= dist_d;
			bear_q <= bear_d;
		end
	end

	assign valid    = valid_q;
	assign distance = dist_q;
	assign bearing  = bear_q;

endmodule

`default_nettype wire

### sv/go_to_goal_controller.sv
// ----------------------------------------------------------------------------
// go_to_goal_controller
// Proportional go-to-goal controller on a row of cordic cells.
// ----------------------------------------------------------------------------
// Each pose beat gives one command beat. The offset to the goal runs through a
// row of CORDIC_STEPS vectoring cordic cells, one rotation per cell and cycle,
// then a gain-correction stage and the speed multiply into the output
// register. A pose is registered on accept, passes the cells and the gain
// register and is then loaded into the output register. A new pose is taken
// only once the previous result is loaded there: the row carries one pose at
// a time because the arrival state is only settled when a pose leaves it.
// Output results are buffered, so the next pose is taken while a command
// still waits on the output. Goal, gain and stop radius are written through
// the cfg port; the user must keep no pose in flight then (not enforced).
`default_nettype none
`include "go_to_goal_controller_macros.svh"

module go_to_goal_controller #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // pose_x[15:0], pose_y[31:16], heading[46:32]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // linear_speed[14:0], turn_rate[30:15]
	output logic [0:0]  m_axis_tuser   // arrived[0]
);
	import gtg_pkg::*;

	localparam int SUM_W = DIST_W + 17;

	// configuration
	logic signed [COORD_W-1:0] goal_x_q;
	logic signed [COORD_W-1:0] goal_y_q;
	logic [15:0]               gain_q;
	logic [15:0]               stop_radius_q;

	// accepted pose
	logic                      start_q;
	logic                      busy_q;
	logic signed [COORD_W-1:0] pose_x_q;
	logic signed [COORD_W-1:0] pose_y_q;
	logic signed [ANGLE_W-1:0] heading_q;

	logic                      accept;
	logic signed [COORD_W:0]   dx;
	logic signed [COORD_W:0]   dy;
	logic signed [X_W-1:0]     dx_w;
	logic signed [X_W-1:0]     dy_w;
	logic                      zero_off;

	logic                      vld [CORDIC_STEPS+1];
	vec_t                      vec [CORDIC_STEPS+1];
	logic [CORDIC_STEPS:0]     vld_vec;

	logic                      sc_valid;
	logic [DIST_W-1:0]         sc_dist;
	logic signed [ANGLE_W-1:0] sc_bearing;
	logic                      load;

	phase_t                    phase_q;
	phase_t                    phase_d;
	logic                      near;
	logic [SUM_W-1:0]          spd_sum;
	logic [SUM_W-9:0]          spd_hi;
	logic [SPEED_W-1:0]        speed_cmd;
	logic signed [TURN_W-1:0]  turn_cmd;
	logic [SPEED_W-1:0]        speed_d;
	logic signed [TURN_W-1:0]  turn_d;
	logic                      arrived_d;

	logic                      out_valid_q;
	logic [SPEED_W-1:0]        speed_q;
	logic signed [TURN_W-1:0]  turn_q;
	logic                      arrived_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q      <= '0;
			goal_y_q      <= '0;
			gain_q        <= 16'd128;
			stop_radius_q <= 16'd128;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GOAL_X:      goal_x_q      <= cfg_data;
				REG_GOAL_Y:      goal_y_q      <= cfg_data;
				REG_GAIN:        gain_q        <= cfg_data;
				REG_STOP_RADIUS: stop_radius_q <= cfg_data;
				default:         goal_x_q      <= goal_x_q;
			endcase
		end
	end

	assign s_axis_tready = !busy_q;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
			busy_q  <= 1'b0;
		end else begin
			start_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pose_x_q  <= s_axis_tdata[15:0];
			pose_y_q  <= s_axis_tdata[31:16];
			heading_q <= s_axis_tdata[46:32];
		end
	end

	// offset to goal in q8.16, folded into the right half plane
	assign dx       = (COORD_W+1)'(goal_x_q) - (COORD_W+1)'(pose_x_q);
	assign dy       = (COORD_W+1)'(goal_y_q) - (COORD_W+1)'(pose_y_q);
	assign dx_w     = X_W'(dx) <<< 8;
	assign dy_w     = X_W'(dy) <<< 8;
	assign zero_off = (dx == '0) && (dy == '0);

	always_comb begin
		vec[0].x = dx_w;
		vec[0].y = dy_w;
		vec[0].z = '0;
		if (dx_w[X_W-1]) begin
			if (!dy_w[X_W-1]) begin
				vec[0].x = dy_w;
				vec[0].y = -dx_w;
				vec[0].z = Z_W'(ANG_HALF_PI);
			end else begin
				vec[0].x = -dy_w;
				vec[0].y = dx_w;
				vec[0].z = -Z_W'(ANG_HALF_PI);
			end
		end
	end

	assign vld[0] = start_q;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		gtg_cordic_cell #(
			.STEP(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vld[i]),
			.in_vec   (vec[i]),
			.out_valid(vld[i+1]),
			.out_vec  (vec[i+1])
		);
	end

	for (genvar i = 0; i <= CORDIC_STEPS; i++) begin : g_vld
		assign vld_vec[i] = vld[i];
	end

	gtg_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(vld[CORDIC_STEPS]),
		.in_vec  (vec[CORDIC_STEPS]),
		.zero    (zero_off),
		.take    (load),
		.valid   (sc_valid),
		.distance(sc_dist),
		.bearing (sc_bearing)
	);

	assign load = sc_valid && (!out_valid_q || m_axis_tready);

	// command arithmetic
	assign spd_sum   = SUM_W'(sc_dist) * SUM_W'(gain_q) + SUM_W'(128);
	assign spd_hi    = spd_sum[SUM_W-1:8];
	assign speed_cmd = (spd_hi > (SUM_W-8)'(SPEED_MAX)) ? SPEED_W'(SPEED_MAX)
	                                                    : spd_hi[SPEED_W-1:0];
	assign turn_cmd  = TURN_W'(sc_bearing) - TURN_W'(heading_q);
	assign near      = (sc_dist < DIST_W'(stop_radius_q));

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_FIRST: phase_d = PH_TRACK;
			PH_TRACK: phase_d = near ? PH_ARRIVED : PH_TRACK;
			default:  phase_d = PH_ARRIVED;
		endcase
	end

	always_comb begin
		speed_d   = '0;
		turn_d    = '0;
		arrived_d = 1'b1;
		unique case (phase_q)
			PH_FIRST: begin
				speed_d   = speed_cmd;
				turn_d    = turn_cmd;
				arrived_d = 1'b0;
			end
			PH_TRACK: begin
				if (!near) begin
					speed_d   = speed_cmd;
					turn_d    = turn_cmd;
					arrived_d = 1'b0;
				end
			end
			default: arrived_d = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q     <= phase_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			speed_q   <= speed_d;
			turn_q    <= turn_d;
			arrived_q <= arrived_d;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {1'b0, turn_q, speed_q};
	assign m_axis_tuser[0] = arrived_q;

	`GTG_ASSERT(a_accept_sets_busy, accept |=> busy_q)
	`GTG_ASSERT(a_one_pose_in_row, $onehot0({vld_vec, sc_valid}))
	`GTG_ASSERT(a_arrived_sticks, $past(phase_q == PH_ARRIVED) |-> phase_q == PH_ARRIVED)
	`GTG_ASSERT(a_arrived_zero_cmd,
		(out_valid_q && arrived_q) |-> (speed_q == '0 && turn_q == '0))

endmodule

`default_nettype wire
